>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the spline evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define ASSERT_ON_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define ASSERT_ON_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_ON_CLK(label, prop, msg)
`define ASSERT_ON_CLK_RST(label, prop, msg)

`endif

`endif

>>> rtl/qse_pkg.sv
// Types and constants shared by the quadratic spline evaluator modules.
`default_nettype none

package qse_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SMP_W     = 32;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 10;
  localparam int CFG_IDX_W = 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN   = 2'd0,
    REG_INV_STEP = 2'd1,
    REG_COUNT    = 2'd2
  } cfg_reg_t;

  localparam logic [SMP_W-1:0] ORIGIN_RST   = 32'hFFFB_0000;
  localparam logic [SMP_W-1:0] INV_STEP_RST = 32'h0002_0000;
  localparam logic [CNT_W-1:0] COUNT_RST    = 10'd20;

  typedef struct packed {
    op_t                     opcode;
    logic [IDX_W-1:0]        sample_index;
    logic signed [SMP_W-1:0] sample_value;
    logic signed [SMP_W-1:0] x_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] spline_value;
    logic                    out_of_range;
  } out_item_t;

  // One store access per cycle: either a sample write or a three-knot read.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_index;
    logic [SMP_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_index;
  } store_req_t;

  // Samples at j-1, j and j+1; an entry beyond the store reads as zero.
  typedef struct packed {
    logic signed [SMP_W-1:0] rm;
    logic signed [SMP_W-1:0] r0;
    logic signed [SMP_W-1:0] rp;
  } knots_t;

endpackage

`default_nettype wire

>>> rtl/quadratic_spline_evaluator_top.sv
// Top level of the quadratic spline evaluator: position pipeline, knot store and blend.
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ------------------------------------------
//   input     in_valid / in_ready    in_item   (opcode, index, sample, x)
//   result    out_valid / out_ready  out_item  (spline_value, out_of_range)
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is taken per cycle while stage one is free.
// The knot store serves one access per cycle at stage five:
// a load writes there and retires, an evaluation reads three neighbours from two banks.
// Reset clears the stage valid bits and the configuration registers; knot samples are undefined until loaded.
// A stall on the result side holds each occupied stage but a load at stage five, while empty stages keep filling.
`default_nettype none

module quadratic_spline_evaluator_top
  import qse_pkg::*;
#(
  parameter int MAX_KNOTS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SMP_W-1:0]     cfg_data
);

`include "assert_macros.svh"

  localparam int F         = FRAC_BITS;
  localparam int NS        = 11;
  localparam int MEM_STAGE = 5;
  localparam int MAG_W     = SMP_W + 1;
  localparam int SPLIT     = 16;
  localparam int HI_P_W    = MAG_W - SPLIT + SMP_W;
  localparam int LO_P_W    = SPLIT + SMP_W;
  localparam int PROD_W    = MAG_W + SMP_W;
  localparam int CAP_W     = 63;
  localparam int V_W       = CAP_W + 1;
  localparam int W_W       = V_W - F;
  localparam int JH_W      = W_W - F;
  localparam int T_W       = F + 1;
  localparam int KW        = SMP_W + 2;
  localparam int WT_W      = F + 2;
  localparam int PW        = KW + WT_W + 1;
  localparam int SUM1_W    = PW + 1;
  localparam int CW        = SUM1_W - (F + 1);
  localparam int P2W       = CW + WT_W + 1;
  localparam int SUM2_W    = P2W + 1;
  localparam int RW        = SUM2_W - F;

  localparam logic [PROD_W-1:0]        PROD_CAP = PROD_W'(1) << (CAP_W - 1);
  localparam logic [W_W-1:0]           HALF_W   = W_W'(1) << (F - 1);
  localparam logic [T_W-1:0]           ONE_T    = T_W'(1) << F;
  localparam logic [WT_W-1:0]          ONE_W    = WT_W'(1) << F;
  localparam logic [WT_W-1:0]          TWO_W    = WT_W'(2) << F;
  localparam logic signed [SUM1_W-1:0] RND1     = SUM1_W'(1) << F;
  localparam logic signed [SUM2_W-1:0] RND2     = SUM2_W'(1) << (F - 1);
  localparam logic [SMP_W-1:0]         SAT_MAX  = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic [SMP_W-1:0]         SAT_MIN  = {1'b1, {(SMP_W-1){1'b0}}};

  // Configuration registers.
  logic signed [SMP_W-1:0] origin;
  logic [SMP_W-1:0]        inverse_step;
  logic [CNT_W-1:0]        interval_count;

  // Stage occupancy and flow control.
  logic [NS:1] full, full_next, free, leave, take;

  // Stage 1: magnitude of x - origin.
  op_t                     s1_op;
  logic [IDX_W-1:0]        s1_index;
  logic [SMP_W-1:0]        s1_sample;
  logic                    s1_neg;
  logic [MAG_W-1:0]        s1_mag;
  // Stage 2: partial products.
  op_t                     s2_op;
  logic [IDX_W-1:0]        s2_index;
  logic [SMP_W-1:0]        s2_sample;
  logic                    s2_neg;
  logic [HI_P_W-1:0]       s2_hi;
  logic [LO_P_W-1:0]       s2_lo;
  // Stage 3: saturated product magnitude.
  op_t                     s3_op;
  logic [IDX_W-1:0]        s3_index;
  logic [SMP_W-1:0]        s3_sample;
  logic                    s3_neg;
  logic [CAP_W-1:0]        s3_psat;
  // Stage 4: signed position with 2F fraction bits.
  op_t                     s4_op;
  logic [IDX_W-1:0]        s4_index;
  logic [SMP_W-1:0]        s4_sample;
  logic [V_W-1:0]          s4_v;
  // Stage 5: nearest knot and offset.
  op_t                     s5_op;
  logic [IDX_W-1:0]        s5_index;
  logic [SMP_W-1:0]        s5_sample;
  logic [IDX_W-1:0]        s5_j;
  logic [T_W-1:0]          s5_t;
  logic                    s5_flag;
  logic [CNT_W-1:0]        s5_n;
  // Stage 6: store read data is valid.
  logic [IDX_W-1:0]        s6_j;
  logic [T_W-1:0]          s6_t;
  logic                    s6_flag;
  logic [CNT_W-1:0]        s6_n;
  // Stage 7: the three knots with end guards, and the weights.
  logic signed [KW-1:0]    s7_sm, s7_s0, s7_sp;
  logic [WT_W-1:0]         s7_wt, s7_w2, s7_w3, s7_w4;
  logic                    s7_flag;
  // Stage 8: first products.
  logic signed [PW-1:0]    s8_m1, s8_m2, s8_m3, s8_m4;
  logic [WT_W-1:0]         s8_wt, s8_w4;
  logic                    s8_flag;
  // Stage 9: rounded intermediate values c and e.
  logic signed [CW-1:0]    s9_c, s9_e;
  logic [WT_W-1:0]         s9_wt, s9_w4;
  logic                    s9_flag;
  // Stage 10: second products.
  logic signed [P2W-1:0]   s10_m5, s10_m6;
  logic                    s10_flag;

  // Combinational values feeding the stage registers.
  logic                    x_below;
  logic [MAG_W-1:0]        diff_up, diff_dn;
  logic [PROD_W-1:0]       prod_sum;
  logic [CAP_W-1:0]        psat_next;
  logic [V_W-1:0]          v_pos;
  logic [W_W-1:0]          w_sum;
  logic [JH_W-1:0]         j_hi;
  logic [CNT_W-1:0]        n_eff;
  logic [IDX_W-1:0]        j_next;
  logic [T_W-1:0]          t_next;
  logic                    flag_next;
  store_req_t              st_req;
  knots_t                  knots;
  logic signed [KW-1:0]    rm_x, r0_x, rp_x, guard_lo, guard_hi;
  logic [WT_W-1:0]         wt_next;
  logic signed [SUM1_W-1:0] sum_c, sum_e;
  logic signed [SUM2_W-1:0] sum_r;
  logic [RW-1:0]           r_full;
  logic [SMP_W-1:0]        r_sat;

  assign cfg_ready = 1'b1;
  assign in_ready  = free[1];
  assign out_valid = full[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      origin         <= ORIGIN_RST;
      inverse_step   <= INV_STEP_RST;
      interval_count <= COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN:   origin         <= cfg_data;
        REG_INV_STEP: inverse_step   <= cfg_data;
        REG_COUNT:    interval_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // A load leaves the memory stage by writing the store, so it never waits on stage six.
  always_comb begin
    leave[NS] = full[NS] & out_ready;
    free[NS]  = ~full[NS] | out_ready;
    for (int k = NS - 1; k >= 1; k--) begin
      if (k == MEM_STAGE) begin
        leave[k] = full[k] & (free[k+1] | (s5_op == OP_LOAD));
      end else begin
        leave[k] = full[k] & free[k+1];
      end
      free[k] = ~full[k] | leave[k];
    end
    take[1] = in_valid & free[1];
    for (int k = 2; k <= NS; k++) begin
      take[k] = leave[k-1];
    end
    take[MEM_STAGE+1] = leave[MEM_STAGE] & (s5_op == OP_EVAL);
    full_next = (full & ~leave) | take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= '0;
    end else begin
      full <= full_next;
    end
  end

  always_comb begin
    x_below   = in_item.x_value < origin;
    diff_up   = {in_item.x_value[SMP_W-1], in_item.x_value} - {origin[SMP_W-1], origin};
    diff_dn   = {origin[SMP_W-1], origin} - {in_item.x_value[SMP_W-1], in_item.x_value};

    prod_sum  = (PROD_W'(s2_hi) << SPLIT) + PROD_W'(s2_lo);
    psat_next = (prod_sum > PROD_CAP) ? PROD_CAP[CAP_W-1:0] : prod_sum[CAP_W-1:0];

    v_pos     = {1'b0, s3_psat};

    // Arithmetic shift of the position is a floor; adding a half picks the nearest knot.
    w_sum     = s4_v[V_W-1:F] + HALF_W;
    j_hi      = w_sum[W_W-1:F];
    n_eff     = (interval_count == '0) ? CNT_W'(1) : interval_count;
    if (w_sum[W_W-1]) begin
      j_next    = '0;
      t_next    = '0;
      flag_next = 1'b1;
    end else if (j_hi > JH_W'(n_eff)) begin
      j_next    = n_eff;
      t_next    = ONE_T;
      flag_next = 1'b1;
    end else begin
      j_next    = j_hi[IDX_W-1:0];
      t_next    = {1'b0, w_sum[F-1:0]};
      flag_next = 1'b0;
    end
  end

  // Store accesses stay in item order: each item touches the store once, at one stage,
  // so a read never overlaps a write to the same entry and no forwarding is needed.
  always_comb begin
    st_req.wr_en    = leave[MEM_STAGE] & (s5_op == OP_LOAD);
    st_req.wr_index = s5_index;
    st_req.wr_data  = s5_sample;
    st_req.rd_en    = take[MEM_STAGE+1];
    st_req.rd_index = s5_j;
  end

  qse_store #(
    .MAX_KNOTS (MAX_KNOTS)
  ) u_store (
    .clk   (clk),
    .req   (st_req),
    .knots (knots)
  );

  always_comb begin
    rm_x     = KW'(knots.rm);
    r0_x     = KW'(knots.r0);
    rp_x     = KW'(knots.rp);
    guard_lo = (r0_x <<< 1) - rp_x;
    guard_hi = (r0_x <<< 1) - rm_x;
    wt_next  = WT_W'(s6_t);

    sum_c = SUM1_W'(s8_m1) + SUM1_W'(s8_m2) + RND1;
    sum_e = SUM1_W'(s8_m3) + SUM1_W'(s8_m4) + RND1;

    sum_r  = SUM2_W'(s10_m5) + SUM2_W'(s10_m6) + RND2;
    r_full = sum_r[SUM2_W-1:F];
    if ((&r_full[RW-1:SMP_W-1]) || !(|r_full[RW-1:SMP_W-1])) begin
      r_sat = r_full[SMP_W-1:0];
    end else begin
      r_sat = r_full[RW-1] ? SAT_MIN : SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (take[1]) begin
      s1_op     <= in_item.opcode;
      s1_index  <= in_item.sample_index;
      s1_sample <= in_item.sample_value;
      s1_neg    <= x_below;
      s1_mag    <= x_below ? diff_dn : diff_up;
    end
    if (take[2]) begin
      s2_op     <= s1_op;
      s2_index  <= s1_index;
      s2_sample <= s1_sample;
      s2_neg    <= s1_neg;
      s2_hi     <= HI_P_W'(s1_mag[MAG_W-1:SPLIT]) * HI_P_W'(inverse_step);
      s2_lo     <= LO_P_W'(s1_mag[SPLIT-1:0]) * LO_P_W'(inverse_step);
    end
    if (take[3]) begin
      s3_op     <= s2_op;
      s3_index  <= s2_index;
      s3_sample <= s2_sample;
      s3_neg    <= s2_neg;
      s3_psat   <= psat_next;
    end
    if (take[4]) begin
      s4_op     <= s3_op;
      s4_index  <= s3_index;
      s4_sample <= s3_sample;
      s4_v      <= s3_neg ? (V_W'(0) - v_pos) : v_pos;
    end
    if (take[5]) begin
      s5_op     <= s4_op;
      s5_index  <= s4_index;
      s5_sample <= s4_sample;
      s5_j      <= j_next;
      s5_t      <= t_next;
      s5_flag   <= flag_next;
      s5_n      <= n_eff;
    end
    if (take[6]) begin
      s6_j    <= s5_j;
      s6_t    <= s5_t;
      s6_flag <= s5_flag;
      s6_n    <= s5_n;
    end
    if (take[7]) begin
      s7_sm   <= (s6_j == '0) ? guard_lo : rm_x;
      s7_s0   <= r0_x;
      s7_sp   <= (s6_j == s6_n) ? guard_hi : rp_x;
      s7_wt   <= wt_next;
      s7_w2   <= TWO_W - wt_next;
      s7_w3   <= wt_next + ONE_W;
      s7_w4   <= ONE_W - wt_next;
      s7_flag <= s6_flag;
    end
    if (take[8]) begin
      s8_m1   <= PW'(s7_sp) * PW'($signed({1'b0, s7_wt}));
      s8_m2   <= PW'(s7_s0) * PW'($signed({1'b0, s7_w2}));
      s8_m3   <= PW'(s7_s0) * PW'($signed({1'b0, s7_w3}));
      s8_m4   <= PW'(s7_sm) * PW'($signed({1'b0, s7_w4}));
      s8_wt   <= s7_wt;
      s8_w4   <= s7_w4;
      s8_flag <= s7_flag;
    end
    if (take[9]) begin
      s9_c    <= sum_c[SUM1_W-1:F+1];
      s9_e    <= sum_e[SUM1_W-1:F+1];
      s9_wt   <= s8_wt;
      s9_w4   <= s8_w4;
      s9_flag <= s8_flag;
    end
    if (take[10]) begin
      s10_m5   <= P2W'(s9_c) * P2W'($signed({1'b0, s9_wt}));
      s10_m6   <= P2W'(s9_e) * P2W'($signed({1'b0, s9_w4}));
      s10_flag <= s9_flag;
    end
    if (take[NS]) begin
      out_item.spline_value <= r_sat;
      out_item.out_of_range <= s10_flag;
    end
  end

  `ASSERT_ON_CLK_RST(a_idle_after_reset, rst |=> !out_valid, "result valid straight after reset")
  `ASSERT_ON_CLK(a_store_one_access, !(st_req.wr_en && st_req.rd_en), "store written and read in one cycle")
  `ASSERT_ON_CLK(a_knot_in_range, full[6] |-> s6_j <= s6_n, "nearest knot beyond the interval count")
  `ASSERT_ON_CLK(a_clamp_ends, (full[6] && s6_flag) |-> ((s6_j == '0 && s6_t == '0) || (s6_j == s6_n && s6_t == ONE_T)), "clamped knot not at an end with matching offset")

endmodule

`default_nettype wire

>>> rtl/qse_store.sv
// Knot sample store split into even and odd banks, giving three neighbours per read.
`default_nettype none

module qse_store
  import qse_pkg::*;
#(
  parameter int MAX_KNOTS = 1024
) (
  input  logic       clk,
  input  store_req_t req,
  output knots_t     knots
);

  localparam int BANK_DEPTH = (MAX_KNOTS + 1) / 2;
  localparam int BAW        = $clog2(BANK_DEPTH);
  localparam int AXW        = (BAW > IDX_W) ? BAW : IDX_W;

  logic [SMP_W-1:0] even_mem [BANK_DEPTH];
  logic [SMP_W-1:0] odd_mem  [BANK_DEPTH];

  logic [AXW-1:0] half_x, half_up_x, half_dn_x, wr_half_x;
  logic [IDX_W:0] idx_m, idx_0, idx_p;
  logic           wr_ok;

  // Read data registers: even bank at h and h+1, odd bank at h-1 and h.
  logic [SMP_W-1:0] ev_h, ev_up, od_dn, od_h;
  logic             odd_sel, ok_m, ok_0, ok_p;

  function automatic logic in_store(input logic [IDX_W:0] i);
    return 32'(i) < 32'(MAX_KNOTS);
  endfunction

  always_comb begin
    half_x    = AXW'(req.rd_index[IDX_W-1:1]);
    half_up_x = half_x + AXW'(1);
    half_dn_x = half_x - AXW'(1);
    wr_half_x = AXW'(req.wr_index[IDX_W-1:1]);
    idx_0     = {1'b0, req.rd_index};
    idx_m     = idx_0 - (IDX_W+1)'(1);
    idx_p     = idx_0 + (IDX_W+1)'(1);
    wr_ok     = in_store({1'b0, req.wr_index});
  end

  always_ff @(posedge clk) begin
    if (req.wr_en && wr_ok) begin
      if (req.wr_index[0]) begin
        odd_mem[wr_half_x[BAW-1:0]] <= req.wr_data;
      end else begin
        even_mem[wr_half_x[BAW-1:0]] <= req.wr_data;
      end
    end
    if (req.rd_en) begin
      ev_h    <= even_mem[half_x[BAW-1:0]];
      ev_up   <= even_mem[half_up_x[BAW-1:0]];
      od_dn   <= odd_mem[half_dn_x[BAW-1:0]];
      od_h    <= odd_mem[half_x[BAW-1:0]];
      odd_sel <= req.rd_index[0];
      ok_m    <= in_store(idx_m);
      ok_0    <= in_store(idx_0);
      ok_p    <= in_store(idx_p);
    end
  end

  always_comb begin
    if (odd_sel) begin
      knots.rm = ev_h;
      knots.r0 = od_h;
      knots.rp = ev_up;
    end else begin
      knots.rm = od_dn;
      knots.r0 = ev_h;
      knots.rp = od_h;
    end
    if (!ok_m) knots.rm = '0;
    if (!ok_0) knots.r0 = '0;
    if (!ok_p) knots.rp = '0;
  end

endmodule

`default_nettype wire
